// ===== design/ac_rms_current_meter_defines.svh =====
// ============================================================================
// AC RMS current meter - assertion macros
// Shared concurrent assertion forms used by the top-level design file.
// ============================================================================
`ifndef AC_RMS_CURRENT_METER_DEFINES_SVH
`define AC_RMS_CURRENT_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACRMS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("acrms assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACRMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("acrms assertion failed");

`endif

// ===== design/acrms_pkg.sv =====
// ============================================================================
// AC RMS current meter - package
// Widths, state encoding and unit request/status types.
// ============================================================================
package acrms_pkg;

    // Parameter defaults
    localparam int DEF_MAX_SAMPLES = 4096;
    localparam int DEF_SAMPLE_BITS = 12;

    // Field and register widths
    localparam int SAMPLE_W    = 12;
    localparam int SPP_W       = 13;
    localparam int MVPA_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int RMS_W       = 16;
    localparam int CUR_W       = 22;
    localparam int SUM_W       = 24;
    localparam int OFFSET_W    = 16;
    localparam int SQSUM_W     = 48;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    localparam logic [SPP_W-1:0]   RESET_SPP  = 13'd400;
    localparam logic [MVPA_W-1:0]  RESET_MVPA = 16'd100;
    localparam logic [CUR_W-1:0]   CUR_MAX    = 22'd4194303;

    // Configuration register indexes
    localparam logic CFG_SAMPLES_PER_PASS   = 1'b0;
    localparam logic CFG_MILLIVOLTS_PER_AMP = 1'b1;

    // Radix-16 squaring unit
    localparam int MUL_W     = 16;
    localparam int DIGIT_W   = 4;
    localparam int MUL_STEPS = MUL_W / DIGIT_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // Bit-serial divider
    localparam int DIV_DEND_W = 48;
    localparam int DIV_DSOR_W = 20;
    localparam int DIV_CNT_W  = $clog2(DIV_DEND_W);

    // Bit-pair serial square root
    localparam int SQRT_IN_W   = 48;
    localparam int SQRT_ROOT_W = SQRT_IN_W / 2;
    localparam int SQRT_REM_W  = SQRT_ROOT_W + 2;
    localparam int SQRT_CNT_W  = $clog2(SQRT_ROOT_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_OFS_DIV,
        ST_MS_DIV,
        ST_SQRT,
        ST_CUR_DIV,
        ST_RESULT
    } acrms_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } acrms_unit_stat_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] operand;
    } acrms_mul_req_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_DEND_W-1:0] dividend;
        logic [DIV_DSOR_W-1:0] divisor;
    } acrms_div_req_t;

    typedef struct packed {
        logic                 start;
        logic [SQRT_IN_W-1:0] radicand;
    } acrms_sqrt_req_t;

endpackage

// ===== design/ac_rms_current_meter.sv =====
// ============================================================================
// AC RMS current meter - top level
// Two-pass DC-removed RMS measurement of a current-transformer signal.
// ============================================================================
// Usage. Samples in millivolts arrive on the s_ stream channel, one per
// transaction. The first samples_per_pass samples form the DC offset; the
// next samples_per_pass samples are squared after removing it. After the last
// sample of that second pass one result transaction appears on the m_
// channel holding the RMS value in 1/16 mV and the current in mA, and the
// block starts a new offset pass. Configuration writes are taken at any
// edge with cfg_wr_en high and should only be made while the block is idle.
// Offset-pass samples are taken back to back; after the last one the channel
// is held off while the 48-step serial divider forms the offset. Each RMS-pass
// sample holds off the channel until the 4-digit squaring unit has squared it.
// The result follows the last sample after squaring, a divide for the mean
// square, a square root and a divide for the current. Reset restores the
// register defaults and starts an offset pass. A stalled receiver holds the
// result in the output register; the block keeps taking samples and only
// waits if a second result is ready before the first has been taken.
// ============================================================================
module ac_rms_current_meter #(
    parameter int MAX_SAMPLES = acrms_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = acrms_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [acrms_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Sample channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [acrms_pkg::IN_TDATA_W-1:0]   s_tdata,   // [11:0] sample_mv
    // Result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [acrms_pkg::OUT_TDATA_W-1:0]  m_tdata    // [15:0] rms_mv_q4, [37:16] current_ma
);
    import acrms_pkg::*;

`include "ac_rms_current_meter_defines.svh"

    // Only the low SAMPLE_BITS bits of a reading count.
    localparam logic [SAMPLE_W-1:0] SampleMask =
        SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    acrms_state_t state_reg, state_next;

    // Configuration registers
    logic [SPP_W-1:0]    spp_reg, spp_next;
    logic [MVPA_W-1:0]   mvpa_reg, mvpa_next;

    // Measurement state
    logic                in_rms_reg, in_rms_next;
    logic [SPP_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [SQSUM_W-1:0]  sqsum_reg, sqsum_next;
    logic                last_reg, last_next;
    logic [SPP_W-1:0]    n_reg, n_next;

    // Result holding and output registers
    logic [RMS_W-1:0]    rms_reg, rms_next;
    logic [CUR_W-1:0]    cur_reg, cur_next;
    logic                m_valid_reg, m_valid_next;
    logic [RMS_W-1:0]    out_rms_reg, out_rms_next;
    logic [CUR_W-1:0]    out_cur_reg, out_cur_next;

    logic                accept;
    logic [SAMPLE_W-1:0] sample;
    logic [SPP_W-1:0]    pass_len;
    logic [SPP_W-1:0]    count_inc;
    logic                pass_end;
    logic [SUM_W-1:0]    sum_add;
    logic [OFFSET_W-1:0] scaled;
    logic [MUL_W-1:0]    diff;
    logic [SQSUM_W-1:0]  sqsum_add;
    logic [MVPA_W-1:0]   mvpa_eff;
    logic [25:0]         rms_wide;
    logic [25:0]         rms_x1000;
    logic                out_free;

    acrms_mul_req_t      mul_req;
    acrms_unit_stat_t    mul_stat;
    logic [2*MUL_W-1:0]  mul_product;
    acrms_div_req_t      div_req;
    acrms_unit_stat_t    div_stat;
    logic [DIV_DEND_W-1:0] div_quotient;
    acrms_sqrt_req_t     sqrt_req;
    acrms_unit_stat_t    sqrt_stat;
    logic [SQRT_ROOT_W-1:0] sqrt_root;

    acrms_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .stat    (mul_stat),
        .product (mul_product)
    );

    acrms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    acrms_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .stat    (sqrt_stat),
        .root    (sqrt_root)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign sample   = s_tdata[SAMPLE_W-1:0] & SampleMask;
    assign out_free = !m_valid_reg || m_tready;

    // Pass length in force: a zero count behaves as one, and the count is
    // capped at the largest supported pass.
    always_comb begin
        pass_len = spp_reg;
        if (spp_reg == '0) begin
            pass_len = SPP_W'(1);
        end else if (int'(spp_reg) > MAX_SAMPLES) begin
            pass_len = SPP_W'(MAX_SAMPLES);
        end
    end

    assign count_inc = count_reg + 1'b1;
    assign pass_end  = (count_inc >= pass_len);
    assign sum_add   = sum_reg + SUM_W'(sample);

    // Deviation of the Q.4 sample from the offset, as a magnitude.
    assign scaled = {sample, 4'b0000};
    assign diff   = (scaled >= offset_reg) ? (scaled - offset_reg) : (offset_reg - scaled);

    assign sqsum_add = sqsum_reg + SQSUM_W'(mul_product);
    assign mvpa_eff  = (mvpa_reg == '0) ? MVPA_W'(1) : mvpa_reg;

    // rms * 1000 as 1024 - 16 - 8 times rms.
    assign rms_wide  = 26'(sqrt_root[RMS_W-1:0]);
    assign rms_x1000 = (rms_wide << 10) - (rms_wide << 4) - (rms_wide << 3);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_rms_reg) begin
                        state_next = ST_SQUARE;
                    end else if (pass_end) begin
                        state_next = ST_OFS_DIV;
                    end
                end
            end
            ST_SQUARE: begin
                if (mul_stat.done) begin
                    state_next = last_reg ? ST_MS_DIV : ST_IDLE;
                end
            end
            ST_OFS_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MS_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sqrt_stat.done) begin
                    state_next = ST_CUR_DIV;
                end
            end
            ST_CUR_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and unit control
    always_comb begin
        spp_next     = spp_reg;
        mvpa_next    = mvpa_reg;
        in_rms_next  = in_rms_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        offset_next  = offset_reg;
        sqsum_next   = sqsum_reg;
        last_next    = last_reg;
        n_next       = n_reg;
        rms_next     = rms_reg;
        cur_next     = cur_reg;
        out_rms_next = out_rms_reg;
        out_cur_next = out_cur_reg;
        m_valid_next = m_valid_reg && !m_tready;

        mul_req      = '0;
        div_req      = '0;
        sqrt_req     = '0;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SAMPLES_PER_PASS:   spp_next  = cfg_wdata[SPP_W-1:0];
                CFG_MILLIVOLTS_PER_AMP: mvpa_next = cfg_wdata[MVPA_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    count_next = count_inc;
                    n_next     = pass_len;
                    if (in_rms_reg) begin
                        last_next       = pass_end;
                        mul_req.start   = 1'b1;
                        mul_req.operand = diff;
                    end else begin
                        sum_next = sum_add;
                        if (pass_end) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DIV_DEND_W'({sum_add, 4'b0000});
                            div_req.divisor  = DIV_DSOR_W'(pass_len);
                        end
                    end
                end
            end
            ST_SQUARE: begin
                if (mul_stat.done) begin
                    sqsum_next = sqsum_add;
                    if (last_reg) begin
                        // Pass over: hand the sum to the divider and start afresh.
                        div_req.start    = 1'b1;
                        div_req.dividend = sqsum_add;
                        div_req.divisor  = DIV_DSOR_W'(n_reg);
                        in_rms_next      = 1'b0;
                        count_next       = '0;
                        sum_next         = '0;
                        sqsum_next       = '0;
                    end
                end
            end
            ST_OFS_DIV: begin
                if (div_stat.done) begin
                    offset_next = div_quotient[OFFSET_W-1:0];
                    in_rms_next = 1'b1;
                    count_next  = '0;
                    sum_next    = '0;
                    sqsum_next  = '0;
                end
            end
            ST_MS_DIV: begin
                if (div_stat.done) begin
                    sqrt_req.start    = 1'b1;
                    sqrt_req.radicand = div_quotient;
                end
            end
            ST_SQRT: begin
                if (sqrt_stat.done) begin
                    rms_next         = sqrt_root[RMS_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_DEND_W'(rms_x1000);
                    div_req.divisor  = {mvpa_eff, 4'b0000};
                end
            end
            ST_CUR_DIV: begin
                if (div_stat.done) begin
                    if (div_quotient > DIV_DEND_W'(CUR_MAX)) begin
                        cur_next = CUR_MAX;
                    end else begin
                        cur_next = div_quotient[CUR_W-1:0];
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    out_rms_next = rms_reg;
                    out_cur_next = cur_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            spp_reg     <= RESET_SPP;
            mvpa_reg    <= RESET_MVPA;
            in_rms_reg  <= 1'b0;
            count_reg   <= '0;
            sum_reg     <= '0;
            offset_reg  <= '0;
            sqsum_reg   <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            spp_reg     <= spp_next;
            mvpa_reg    <= mvpa_next;
            in_rms_reg  <= in_rms_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            offset_reg  <= offset_next;
            sqsum_reg   <= sqsum_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        rms_reg     <= rms_next;
        cur_reg     <= cur_next;
        out_rms_reg <= out_rms_next;
        out_cur_reg <= out_cur_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_cur_reg, out_rms_reg};

    // A sample is only taken with every arithmetic unit at rest.
    `ACRMS_ASSERT_IMP(a_ready_units_idle, aclk, aresetn, s_tready,
        !mul_stat.busy && !div_stat.busy && !sqrt_stat.busy)
    // Unit completions only arrive in the state that waits for them.
    `ACRMS_ASSERT_IMP(a_mul_done_state, aclk, aresetn, mul_stat.done,
        state_reg == ST_SQUARE)
    `ACRMS_ASSERT_IMP(a_div_done_state, aclk, aresetn, div_stat.done,
        state_reg == ST_OFS_DIV || state_reg == ST_MS_DIV || state_reg == ST_CUR_DIV)
    // Leaving the result state always presents a result transaction.
    `ACRMS_ASSERT_NEXT(a_result_presented, aclk, aresetn,
        state_reg == ST_RESULT && out_free, m_tvalid)

endmodule

// ===== design/acrms_mul.sv =====
// ============================================================================
// AC RMS current meter - digit-serial squaring unit
// Squares a 16-bit operand, one 4-bit digit of the multiplier per cycle.
// ============================================================================
module acrms_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  acrms_pkg::acrms_mul_req_t     req,
    output acrms_pkg::acrms_unit_stat_t   stat,
    output logic [2*acrms_pkg::MUL_W-1:0] product
);
    import acrms_pkg::*;

    logic [MUL_W-1:0]         mcand_reg, mcand_next;
    logic [MUL_W-1:0]         mplier_reg, mplier_next;
    logic [2*MUL_W-1:0]       prod_reg, prod_next;
    logic [MUL_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [MUL_W+DIGIT_W-1:0] pp;
    logic [MUL_W+DIGIT_W-1:0] hi;

    assign pp = (MUL_W+DIGIT_W)'(mcand_reg) * (MUL_W+DIGIT_W)'(mplier_reg[DIGIT_W-1:0]);
    assign hi = (MUL_W+DIGIT_W)'(prod_reg[2*MUL_W-1:MUL_W]) + pp;

    always_comb begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start) begin
            mcand_next  = req.operand;
            mplier_next = req.operand;
            prod_next   = '0;
            cnt_next    = MUL_CNT_W'(MUL_STEPS - 1);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            // Add the partial product to the upper half, then shift one digit right.
            prod_next   = {hi, prod_reg[MUL_W-1:DIGIT_W]};
            mplier_next = mplier_reg >> DIGIT_W;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = prod_reg;

endmodule

// ===== design/acrms_div.sv =====
// ============================================================================
// AC RMS current meter - bit-serial divider
// Restoring division, one quotient bit per cycle, shared by all divisions.
// ============================================================================
module acrms_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  acrms_pkg::acrms_div_req_t      req,
    output acrms_pkg::acrms_unit_stat_t    stat,
    output logic [acrms_pkg::DIV_DEND_W-1:0] quotient
);
    import acrms_pkg::*;

    logic [DIV_DSOR_W-1:0] rem_reg, rem_next;
    logic [DIV_DEND_W-1:0] quo_reg, quo_next;
    logic [DIV_DSOR_W-1:0] dsor_reg, dsor_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_DSOR_W:0]   shifted;
    logic [DIV_DSOR_W:0]   trial;

    // The dividend shifts out of the top of the quotient register into the
    // partial remainder while quotient bits shift in at the bottom.
    assign shifted = {rem_reg, quo_reg[DIV_DEND_W-1]};
    assign trial   = shifted - {1'b0, dsor_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsor_next = dsor_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsor_next = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_DEND_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIV_DSOR_W]) begin
                rem_next = trial[DIV_DSOR_W-1:0];
                quo_next = {quo_reg[DIV_DEND_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_DSOR_W-1:0];
                quo_next = {quo_reg[DIV_DEND_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsor_reg <= dsor_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== design/acrms_sqrt.sv =====
// ============================================================================
// AC RMS current meter - serial square root
// Floor square root, one bit pair of the radicand per cycle.
// ============================================================================
module acrms_sqrt (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  acrms_pkg::acrms_sqrt_req_t       req,
    output acrms_pkg::acrms_unit_stat_t      stat,
    output logic [acrms_pkg::SQRT_ROOT_W-1:0] root
);
    import acrms_pkg::*;

    logic [SQRT_IN_W-1:0]   rad_reg, rad_next;
    logic [SQRT_REM_W-1:0]  rem_reg, rem_next;
    logic [SQRT_ROOT_W-1:0] root_reg, root_next;
    logic [SQRT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [SQRT_REM_W+1:0]  r2;
    logic [SQRT_REM_W+1:0]  trial;
    logic [SQRT_REM_W+1:0]  diff;

    assign r2    = {rem_reg, rad_reg[SQRT_IN_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign diff  = r2 - trial;

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rad_next  = req.radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = SQRT_CNT_W'(SQRT_ROOT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[SQRT_IN_W-3:0], 2'b00};
            if (!diff[SQRT_REM_W+1]) begin
                rem_next  = diff[SQRT_REM_W-1:0];
                root_next = {root_reg[SQRT_ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = r2[SQRT_REM_W-1:0];
                root_next = {root_reg[SQRT_ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule
